// ===== rtl/pxa_pkg.sv =====
package pxa_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	// divisor magnitude: one bit above the data width
	localparam int DEN_W      = DATA_WIDTH + 1;
	// dividend magnitude: pixel (doubled when guarded) shifted up by the fraction
	localparam int NUM_W      = DATA_WIDTH + 1 + FRAC_BITS;

	typedef enum logic [2:0] {
		OP_SUM  = 3'd0,
		OP_DIFF = 3'd1,
		OP_PROD = 3'd2,
		OP_WSUM = 3'd3,
		OP_SSQ  = 3'd4,
		OP_DIV  = 3'd5
	} op_t;

	localparam logic [1:0] CFG_WEIGHT_A  = 2'd0;
	localparam logic [1:0] CFG_WEIGHT_B  = 2'd1;
	localparam logic [1:0] CFG_THRESHOLD = 2'd2;
	localparam logic [1:0] CFG_OFFSET    = 2'd3;

	typedef struct packed {
		logic [2:0]                    opcode;
		logic signed [DATA_WIDTH-1:0]  pixel_a;
		logic signed [DATA_WIDTH-1:0]  pixel_b;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0]  result;
		logic                          saturated;
		logic                          guard_used;
	} out_item_t;

	// sideband that rides along the divider stages
	typedef struct packed {
		logic                   is_div;
		logic                   guard;
		logic                   neg;
		logic                   zero;
		logic                   num_neg;
		logic [DATA_WIDTH-1:0]  ares;
		logic                   asat;
	} div_tag_t;

endpackage

// ===== rtl/pxa_div.sv =====
module pxa_div (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_v,
	input  pxa_pkg::div_tag_t       in_tag,
	input  logic [pxa_pkg::NUM_W-1:0] in_num,
	input  logic [pxa_pkg::DEN_W-1:0] in_den,
	output logic                    out_v,
	output pxa_pkg::div_tag_t       out_tag,
	output logic [pxa_pkg::NUM_W-1:0] out_quo
);
	import pxa_pkg::*;

	// one quotient bit per stage, restoring
	logic             v_s   [1:NUM_W];
	div_tag_t         tag_s [1:NUM_W];
	logic [DEN_W-1:0] rem_s [1:NUM_W];
	logic [NUM_W-1:0] dq_s  [1:NUM_W];
	logic [DEN_W-1:0] den_s [1:NUM_W];

	for (genvar i = 0; i < NUM_W; i++) begin : g_stage
		logic             v_i;
		div_tag_t         tag_i;
		logic [DEN_W-1:0] rem_i;
		logic [NUM_W-1:0] dq_i;
		logic [DEN_W-1:0] den_i;
		logic [DEN_W:0]   shifted;
		logic [DEN_W:0]   trial;

		if (i == 0) begin : g_first
			assign v_i   = in_v;
			assign tag_i = in_tag;
			assign rem_i = '0;
			assign dq_i  = in_num;
			assign den_i = in_den;
		end else begin : g_next
			assign v_i   = v_s[i];
			assign tag_i = tag_s[i];
			assign rem_i = rem_s[i];
			assign dq_i  = dq_s[i];
			assign den_i = den_s[i];
		end

		assign shifted = {rem_i, dq_i[NUM_W-1]};
		assign trial   = shifted - {1'b0, den_i};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_s[i+1] <= tag_i;
				den_s[i+1] <= den_i;
				if (!trial[DEN_W]) begin
					rem_s[i+1] <= trial[DEN_W-1:0];
					dq_s[i+1]  <= {dq_i[NUM_W-2:0], 1'b1};
				end else begin
					rem_s[i+1] <= shifted[DEN_W-1:0];
					dq_s[i+1]  <= {dq_i[NUM_W-2:0], 1'b0};
				end
			end
		end
	end

	assign out_v   = v_s[NUM_W];
	assign out_tag = tag_s[NUM_W];
	assign out_quo = dq_s[NUM_W];

`ifndef SYNTH
	a_guard_is_div: assert property (@(posedge clk) disable iff (!arst_n)
		out_v && out_tag.guard |-> out_tag.is_div)
		else $error("guard flag on a non-divide request");
	a_zero_is_div: assert property (@(posedge clk) disable iff (!arst_n)
		out_v && out_tag.zero |-> out_tag.is_div)
		else $error("zero divisor on a non-divide request");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(out_v))
		else $error("divider stage moved while held");
`endif
endmodule

// ===== rtl/pixel_pair_arithmetic_unit.sv =====
// pixel pair arithmetic unit
// in channel: in_valid / in_stall / in_data carries one request of opcode,
// pixel_a and pixel_b (signed q16.16); out channel: out_valid / out_stall /
// out_data returns result, saturated and guard_used for every request.
// opcodes: sum, difference, product, weighted sum, sum of squares and
// guarded divide; all results clamp to 32 signed bits and set saturated.
// configuration: cfg_we writes cfg_data into register cfg_index (weight_a,
// weight_b, div_threshold, div_offset); write only when idle.
// pipeline: every opcode takes the same path, through the operand stage,
// the divide setup stage, the 49 stage restoring divider (one quotient bit
// a stage) and the output register.
// throughput: one request per clock while out_stall does not hold the pipe.
// stall: the whole pipe advances together; while out_valid is high and
// out_stall is high every stage holds and in_stall is raised, nothing lost.
// reset: arst_n clears all valid bits and loads weights to 1.0, threshold
// and offset to 0; no request is taken until arst_n is released.
module pixel_pair_arithmetic_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  pxa_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output pxa_pkg::out_item_t out_data,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [pxa_pkg::DATA_WIDTH-1:0] cfg_data
);
	import pxa_pkg::*;

	localparam int DW = DATA_WIDTH;
	localparam int PW = 2 * DW;
	localparam int SW = PW + 1 - FRAC_BITS;
	localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

	// configuration registers
	logic signed [DW-1:0] weight_a_q, weight_b_q, div_offset_q;
	logic        [DW-2:0] div_threshold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_a_q      <= DW'(1) << FRAC_BITS;
			weight_b_q      <= DW'(1) << FRAC_BITS;
			div_threshold_q <= '0;
			div_offset_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WEIGHT_A:  weight_a_q      <= cfg_data;
				CFG_WEIGHT_B:  weight_b_q      <= cfg_data;
				CFG_THRESHOLD: div_threshold_q <= cfg_data[DW-2:0];
				CFG_OFFSET:    div_offset_q    <= cfg_data;
				default:       ;
			endcase
		end
	end

	// whole pipe moves when the output slot is free or being taken
	logic en;
	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	// stage 1: products, add/sub, guard decision
	logic signed [DW-1:0] ma, mb, mc, md;
	logic signed [DW:0]   addsub;
	logic signed [DW:0]   abs_q, num_c, den_c;
	logic                 guard_c;

	always_comb begin
		ma = '0; mb = '0; mc = '0; md = '0;
		case (in_data.opcode)
			OP_PROD: begin ma = in_data.pixel_a; mb = in_data.pixel_b; end
			OP_WSUM: begin
				ma = weight_a_q; mb = in_data.pixel_a;
				mc = weight_b_q; md = in_data.pixel_b;
			end
			OP_SSQ: begin
				ma = in_data.pixel_a; mb = in_data.pixel_a;
				mc = in_data.pixel_b; md = in_data.pixel_b;
			end
			default: ;
		endcase
		if (in_data.opcode == OP_DIFF)
			addsub = {in_data.pixel_a[DW-1], in_data.pixel_a}
				- {in_data.pixel_b[DW-1], in_data.pixel_b};
		else
			addsub = {in_data.pixel_a[DW-1], in_data.pixel_a}
				+ {in_data.pixel_b[DW-1], in_data.pixel_b};
		abs_q   = in_data.pixel_b[DW-1]
			? -{in_data.pixel_b[DW-1], in_data.pixel_b}
			: {1'b0, in_data.pixel_b};
		guard_c = $unsigned(abs_q) <= {2'b00, div_threshold_q};
		if (guard_c) begin
			num_c = {in_data.pixel_a, 1'b0};
			den_c = {in_data.pixel_b[DW-1], in_data.pixel_b}
				+ {div_offset_q[DW-1], div_offset_q};
		end else begin
			num_c = {in_data.pixel_a[DW-1], in_data.pixel_a};
			den_c = {in_data.pixel_b[DW-1], in_data.pixel_b};
		end
	end

	logic                 v_s1;
	logic [2:0]           op_s1;
	logic signed [PW-1:0] p1_s1, p2_s1;
	logic signed [DW:0]   addsub_s1, num_s1, den_s1;
	logic                 guard_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1     <= in_data.opcode;
			p1_s1     <= ma * mb;
			p2_s1     <= mc * md;
			addsub_s1 <= addsub;
			num_s1    <= num_c;
			den_s1    <= den_c;
			guard_s1  <= guard_c;
		end
	end

	// stage 2: product sum with floor shift and clamp, divider setup
	logic signed [PW:0]   psum;
	logic signed [SW-1:0] pshift, pick;
	logic [DW-1:0]        ares;
	logic                 asat;
	div_tag_t             tag_c;
	logic [DW:0]          mag_num, mag_den;

	always_comb begin
		psum   = {p1_s1[PW-1], p1_s1} + {p2_s1[PW-1], p2_s1};
		pshift = SW'(psum >>> FRAC_BITS);
		if (op_s1 == OP_SUM || op_s1 == OP_DIFF)
			pick = {{(SW-DW-1){addsub_s1[DW]}}, addsub_s1};
		else
			pick = pshift;
		if (pick > SW'(MAXV)) begin
			ares = MAXV; asat = 1'b1;
		end else if (pick < $signed({{(SW-DW){1'b1}}, MINV})) begin
			ares = MINV; asat = 1'b1;
		end else begin
			ares = pick[DW-1:0]; asat = 1'b0;
		end
		// unused opcodes give zero
		if (op_s1 > OP_DIV) begin
			ares = '0; asat = 1'b0;
		end
		mag_num = num_s1[DW] ? -num_s1 : num_s1;
		mag_den = den_s1[DW] ? -den_s1 : den_s1;
		tag_c.is_div  = (op_s1 == OP_DIV);
		tag_c.guard   = (op_s1 == OP_DIV) && guard_s1;
		tag_c.neg     = num_s1[DW] ^ den_s1[DW];
		tag_c.zero    = (op_s1 == OP_DIV) && (den_s1 == '0);
		tag_c.num_neg = num_s1[DW];
		tag_c.ares    = ares;
		tag_c.asat    = asat;
	end

	logic                v_s2;
	div_tag_t            tag_s2;
	logic [NUM_W-1:0]    num_s2;
	logic [DEN_W-1:0]    den_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s2 <= tag_c;
			num_s2 <= {mag_num, {FRAC_BITS{1'b0}}};
			den_s2 <= mag_den;
		end
	end

	// divider stages, sideband travels alongside
	logic             dv;
	div_tag_t         dtag;
	logic [NUM_W-1:0] quo;

	pxa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (v_s2),
		.in_tag (tag_s2),
		.in_num (num_s2),
		.in_den (den_s2),
		.out_v  (dv),
		.out_tag(dtag),
		.out_quo(quo)
	);

	// final stage: signed quotient clamp and output register
	out_item_t res_c;

	always_comb begin
		res_c.guard_used = dtag.guard;
		if (!dtag.is_div) begin
			res_c.result    = dtag.ares;
			res_c.saturated = dtag.asat;
		end else if (dtag.zero) begin
			res_c.result    = dtag.num_neg ? MINV : MAXV;
			res_c.saturated = 1'b1;
		end else if (!dtag.neg || quo == '0) begin
			if (quo > NUM_W'(MAXV)) begin
				res_c.result = MAXV; res_c.saturated = 1'b1;
			end else begin
				res_c.result = quo[DW-1:0]; res_c.saturated = 1'b0;
			end
		end else if (quo > NUM_W'(MAXV) + NUM_W'(1)) begin
			res_c.result    = MINV;
			res_c.saturated = 1'b1;
		end else begin
			res_c.result    = -quo[DW-1:0];
			res_c.saturated = 1'b0;
		end
	end

	logic      out_valid_q;
	out_item_t out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= res_c;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTH
	a_stall_back: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input held without a stalled result");
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(v_s1) && $stable(v_s2))
		else $error("front stages moved while stalled");
	a_guard_out: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && tag_s2.guard |-> tag_s2.is_div)
		else $error("guard on a non-divide request");
`endif
endmodule
